@@ hw/rtl/bst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream tokenizer package
// Word types, token kinds, character classes and control/status structs
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Token kinds.
  localparam logic [3:0] K_EOF     = 4'd0;
  localparam logic [3:0] K_INT     = 4'd1;
  localparam logic [3:0] K_PRINT   = 4'd2;
  localparam logic [3:0] K_IDENT   = 4'd3;
  localparam logic [3:0] K_NUMBER  = 4'd4;
  localparam logic [3:0] K_ASSIGN  = 4'd5;
  localparam logic [3:0] K_PLUS    = 4'd6;
  localparam logic [3:0] K_MINUS   = 4'd7;
  localparam logic [3:0] K_MUL     = 4'd8;
  localparam logic [3:0] K_DIV     = 4'd9;
  localparam logic [3:0] K_LPAREN  = 4'd10;
  localparam logic [3:0] K_RPAREN  = 4'd11;
  localparam logic [3:0] K_SEMI    = 4'd12;
  localparam logic [3:0] K_UNKNOWN = 4'd13;

  // Character classes.
  localparam logic [2:0] CL_SPACE  = 3'd0;
  localparam logic [2:0] CL_LETTER = 3'd1;
  localparam logic [2:0] CL_DIGIT  = 3'd2;
  localparam logic [2:0] CL_LT     = 3'd3;
  localparam logic [2:0] CL_OP     = 3'd4;
  localparam logic [2:0] CL_OTHER  = 3'd5;

  // Sources of the text byte of a result.
  localparam logic [2:0] TXT_NONE  = 3'd0;
  localparam logic [2:0] TXT_MEM   = 3'd1;
  localparam logic [2:0] TXT_HOLD  = 3'd2;
  localparam logic [2:0] TXT_LT    = 3'd3;
  localparam logic [2:0] TXT_MINUS = 3'd4;

  // Characters.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // Keyword spellings, padded with zero.
  localparam logic [7:0] KW_INT   [0:3] = '{8'h69, 8'h6E, 8'h74, 8'h00};
  localparam logic [7:0] KW_PRINT [0:7] = '{8'h70, 8'h72, 8'h69, 8'h6E,
                                            8'h74, 8'h00, 8'h00, 8'h00};

  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] text_byte;
    logic [5:0] text_len;
    logic       truncated;
    logic       token_end;
    logic       run_end;
  } out_word_t;

  typedef struct packed {
    logic       hold_load;
    logic       use_hold;
    logic       st_first;
    logic       st_next;
    logic       st_hold;
    logic       run_clr;
    logic       idx_clr;
    logic       idx_inc;
    logic       num_mode;
    logic       out_load;
    logic [3:0] out_kind;
    logic [2:0] out_txt;
    logic       out_run_len;
    logic [1:0] out_len;
    logic       token_end;
    logic       run_end;
  } bst_cmd_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] op_kind;
    logic [3:0] run_kind;
    logic       last_byte;
    logic       out_free;
  } bst_stat_t;

  function automatic logic [2:0] char_class(input logic [7:0] c);
    logic [2:0] cls;
    cls = CL_OTHER;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      cls = CL_SPACE;
    end else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
      cls = CL_LETTER;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      cls = CL_DIGIT;
    end else if (c == CH_LT) begin
      cls = CL_LT;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                 c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI) begin
      cls = CL_OP;
    end
    return cls;
  endfunction

  function automatic logic [3:0] op_kind_of(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_MUL;
      CH_SLASH:  k = K_DIV;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_SEMI:   k = K_SEMI;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bst_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream tokenizer datapath
// Text store, fill count, keyword trackers, replay index and the output
// register.
// ----------------------------------------------------------------------------
module bst_datapath #(
  parameter int MAX_TEXT = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_byte,
  input  wire bst_pkg::bst_cmd_t cmd,
  input  wire logic              out_ready,
  output bst_pkg::bst_stat_t     stat,
  output logic                   out_valid,
  output bst_pkg::out_word_t     out_data
);
  import bst_pkg::*;

  localparam int AW = $clog2(MAX_TEXT);
  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TEXT);

  logic [7:0]    mem [MAX_TEXT];
  logic [7:0]    rdata_r;
  logic [7:0]    hold_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          int_ok_r, int_ok_nxt;
  logic          prt_ok_r, prt_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_r, out_nxt;
  logic [7:0]    cur_byte;
  logic [7:0]    wr_byte;
  logic [CW-1:0] wr_pos;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic          int_hit, prt_hit;
  logic [CW+5:0] len_ext;

  // Text store, fill count and keyword match tracking.
  always_comb begin
    cur_byte   = cmd.use_hold ? hold_r : in_byte;
    wr_byte    = cmd.st_hold ? hold_r : in_byte;
    wr_pos     = cmd.st_first ? '0 : count_r;
    int_hit    = (wr_pos < CW'(3)) ? (wr_byte == KW_INT[wr_pos[1:0]]) : 1'b1;
    prt_hit    = (wr_pos < CW'(5)) ? (wr_byte == KW_PRINT[wr_pos[2:0]]) : 1'b1;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    int_ok_nxt = int_ok_r;
    prt_ok_nxt = prt_ok_r;
    wr_en      = 1'b0;
    if (cmd.run_clr) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
    if (cmd.st_first || cmd.st_next) begin
      if (wr_pos < MAX_CNT) begin
        wr_en      = 1'b1;
        count_nxt  = wr_pos + CW'(1);
        int_ok_nxt = (cmd.st_first | int_ok_r) & int_hit;
        prt_ok_nxt = (cmd.st_first | prt_ok_r) & prt_hit;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (cmd.st_first) begin
        ovf_nxt = 1'b0;
      end
    end
  end

  // Replay index; the read address follows the next index, or is zero once that index reaches the store size.
  always_comb begin
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end else begin
      idx_nxt = idx_r;
    end
    rd_addr = (idx_nxt < MAX_CNT) ? idx_nxt[AW-1:0] : '0;
  end

  // Status toward the controller.
  always_comb begin
    stat.cls       = char_class(cur_byte);
    stat.op_kind   = op_kind_of(cur_byte);
    stat.last_byte = (idx_r + CW'(1)) == count_r;
    stat.out_free  = !out_valid_r || out_ready;
    if (cmd.num_mode) begin
      stat.run_kind = K_NUMBER;
    end else if (!ovf_r && count_r == CW'(3) && int_ok_r) begin
      stat.run_kind = K_INT;
    end else if (!ovf_r && count_r == CW'(5) && prt_ok_r) begin
      stat.run_kind = K_PRINT;
    end else begin
      stat.run_kind = K_IDENT;
    end
  end

  // Output register.
  always_comb begin
    len_ext            = {6'd0, count_r};
    out_nxt            = out_r;
    out_valid_nxt      = out_ready ? 1'b0 : out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt     = 1'b1;
      out_nxt.kind      = cmd.out_kind;
      out_nxt.text_len  = cmd.out_run_len ? len_ext[5:0] : {4'd0, cmd.out_len};
      out_nxt.truncated = cmd.out_run_len & ovf_r;
      out_nxt.token_end = cmd.token_end;
      out_nxt.run_end   = cmd.run_end;
      unique case (cmd.out_txt)
        TXT_MEM:   out_nxt.text_byte = rdata_r;
        TXT_HOLD:  out_nxt.text_byte = hold_r;
        TXT_LT:    out_nxt.text_byte = CH_LT;
        TXT_MINUS: out_nxt.text_byte = CH_MINUS;
        default:   out_nxt.text_byte = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[AW-1:0]] <= wr_byte;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold_r <= in_byte;
    end
    int_ok_r <= int_ok_nxt;
    prt_ok_r <= prt_ok_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ hw/rtl/bst_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream tokenizer controller
// Scan mode and sequencing state machine that drives the datapath.
// ----------------------------------------------------------------------------
module bst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_action,
  input  wire bst_pkg::bst_stat_t stat,
  output logic                    in_ready,
  output bst_pkg::bst_cmd_t       cmd
);
  import bst_pkg::*;

  localparam logic [3:0] S_WAIT   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_REPLAY = 4'd2;
  localparam logic [3:0] S_POST   = 4'd3;
  localparam logic [3:0] S_OP     = 4'd4;
  localparam logic [3:0] S_UNK    = 4'd5;
  localparam logic [3:0] S_ASG0   = 4'd6;
  localparam logic [3:0] S_ASG1   = 4'd7;
  localparam logic [3:0] S_EOF    = 4'd8;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_LT   = 2'd3;

  logic [3:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       pend_eof_r, pend_eof_nxt;
  logic       post_emits_r, post_emits_nxt;
  logic       in_fire;
  logic       dispatch;
  logic       flush_emits;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    pend_eof_nxt   = pend_eof_r;
    post_emits_nxt = post_emits_r;
    in_ready       = (state_r == S_WAIT);
    in_fire        = in_ready && in_valid;
    cmd.hold_load  = in_fire;
    cmd.use_hold   = (state_r != S_WAIT);
    cmd.num_mode   = (mode_r == MODE_NUM);
    dispatch       = (state_r == S_POST) ||
                     (in_fire && !in_action && mode_r == MODE_IDLE);
    // The byte that ends a run yields a token of its own only when it is an
    // operator or an unknown byte.
    flush_emits    = (stat.cls == CL_OP) || (stat.cls == CL_OTHER);

    unique case (state_r)
      S_WAIT: begin
        if (in_fire) begin
          pend_eof_nxt = in_action;
          if (in_action) begin
            post_emits_nxt = 1'b1;
            // An open run keeps its mode until its replay ends, so that a
            // number is still reported as a number.
            unique case (mode_r)
              MODE_WORD, MODE_NUM: state_nxt = S_PREP;
              MODE_LT: begin
                mode_nxt  = MODE_IDLE;
                state_nxt = S_UNK;
              end
              default: begin
                mode_nxt  = MODE_IDLE;
                state_nxt = S_EOF;
              end
            endcase
          end else begin
            unique case (mode_r)
              MODE_LT: begin
                mode_nxt = MODE_IDLE;
                if (stat.cls == CL_OP && stat.op_kind == K_MINUS) begin
                  state_nxt = S_ASG0;
                end else begin
                  state_nxt = S_UNK;
                end
              end
              MODE_WORD: begin
                if (stat.cls == CL_LETTER || stat.cls == CL_DIGIT) begin
                  cmd.st_next = 1'b1;
                end else begin
                  state_nxt      = S_PREP;
                  post_emits_nxt = flush_emits;
                end
              end
              MODE_NUM: begin
                if (stat.cls == CL_DIGIT) begin
                  cmd.st_next = 1'b1;
                end else begin
                  state_nxt      = S_PREP;
                  post_emits_nxt = flush_emits;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_PREP: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = S_REPLAY;
      end
      S_REPLAY: begin
        cmd.out_kind    = stat.run_kind;
        cmd.out_txt     = TXT_MEM;
        cmd.out_run_len = 1'b1;
        cmd.token_end   = stat.last_byte;
        cmd.run_end     = stat.last_byte && !post_emits_r;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_inc  = 1'b1;
          if (stat.last_byte) begin
            cmd.run_clr = 1'b1;
            mode_nxt    = MODE_IDLE;
            state_nxt   = pend_eof_r ? S_EOF : S_POST;
          end
        end
      end
      S_POST: begin
        state_nxt = S_WAIT;
      end
      S_OP: begin
        cmd.out_kind  = stat.op_kind;
        cmd.out_txt   = TXT_HOLD;
        cmd.out_len   = 2'd1;
        cmd.token_end = 1'b1;
        cmd.run_end   = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_UNK: begin
        cmd.out_kind  = K_UNKNOWN;
        cmd.out_txt   = TXT_NONE;
        cmd.token_end = 1'b1;
        cmd.run_end   = !pend_eof_r;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = pend_eof_r ? S_EOF : S_WAIT;
        end
      end
      S_ASG0: begin
        cmd.out_kind = K_ASSIGN;
        cmd.out_txt  = TXT_LT;
        cmd.out_len  = 2'd2;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_ASG1;
        end
      end
      S_ASG1: begin
        cmd.out_kind  = K_ASSIGN;
        cmd.out_txt   = TXT_MINUS;
        cmd.out_len   = 2'd2;
        cmd.token_end = 1'b1;
        cmd.run_end   = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_EOF: begin
        cmd.out_kind  = K_EOF;
        cmd.out_txt   = TXT_NONE;
        cmd.token_end = 1'b1;
        cmd.run_end   = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase

    // A byte seen in idle mode, either fresh or the one that closed a run.
    if (dispatch) begin
      cmd.st_hold = (state_r == S_POST);
      unique case (stat.cls)
        CL_LETTER: begin
          cmd.st_first = 1'b1;
          mode_nxt     = MODE_WORD;
        end
        CL_DIGIT: begin
          cmd.st_first = 1'b1;
          mode_nxt     = MODE_NUM;
        end
        CL_LT:    mode_nxt  = MODE_LT;
        CL_OP:    state_nxt = S_OP;
        CL_OTHER: state_nxt = S_UNK;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_WAIT;
      mode_r       <= MODE_IDLE;
      pend_eof_r   <= 1'b0;
      post_emits_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      pend_eof_r   <= pend_eof_nxt;
      post_emits_r <= post_emits_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/byte_stream_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Turns a stream of source bytes into keyword, identifier, number,
// operator, assign, unknown and eof tokens, one word per token text byte.
// ----------------------------------------------------------------------------
// Usage: each input word carries one source byte, or an end-of-stream mark
// when action is set. Each output word carries one byte of token text with
// the token kind, the stored text length and the truncated flag; token_end
// marks the last word of a token and run_end the last word caused by one
// input word. Tokens with empty text (unknown, eof) take one output word.
// Timing: a byte that only extends a word or a number is stored as it is
// accepted. When a run closes, a read setup state is followed by the replay
// of the text store, one stored byte per cycle while the output is free,
// then a state in which the closing byte is handled again and one more if
// it starts a token of its own. Other tokens give one output word per cycle
// while the output is free, once the byte is accepted. The replay of the
// text store sets the rate over a whole stream.
// Stalls: results go out through an output register, so a held out_ready
// simply freezes the replay; nothing is dropped. in_ready stays low while
// the results of the previous word are still being produced.
// Reset: rst_n is synchronous and active low; it returns the scanner to
// idle with an empty text store and no output word pending.
module byte_stream_tokenizer #(
  parameter int MAX_TEXT = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bst_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bst_pkg::out_word_t      out_data
);
  import bst_pkg::*;

  bst_cmd_t  cmd;
  bst_stat_t stat;

  // The controller tracks the scan mode and sequences every token.
  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // The datapath holds the text, classifies bytes and owns the output word.
  bst_datapath #(
    .MAX_TEXT (MAX_TEXT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_data.char_byte),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // The last word of an input's results always closes a token.
  a_run_end_closes_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_end |-> out_data.token_end)
    else $error("run_end set on a word that does not end its token");

  // Tokens with empty text come as a single zero byte.
  a_empty_text_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_EOF || out_data.kind == K_UNKNOWN) |->
      out_data.text_len == 6'd0 && out_data.text_byte == 8'd0 && out_data.token_end)
    else $error("token with empty text is not a single zero word");

  // A cut token always reports a full text store.
  a_truncated_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.truncated |-> out_data.text_len == 6'(MAX_TEXT))
    else $error("truncated token without a full text length");

  // End of stream always produces results, so the input side must close.
  a_eof_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action |=> !in_ready)
    else $error("end of stream accepted without producing results");

endmodule
`default_nettype wire
